// ===== hdl/tthg_pkg.sv =====
// ----------------------------------------------------------------------------
// tthg_pkg
// Types and constants shared by the tap/hold gesture detector modules.
// ----------------------------------------------------------------------------
package tthg_pkg;

  localparam int TIME_W   = 32;
  localparam int LEVEL_W  = 10;
  localparam int MS_W     = 16;
  localparam int COUNT_W  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 16;

  localparam logic [LEVEL_W-1:0] THRESHOLD_RST = 10'd500;
  localparam logic [MS_W-1:0]    TAP_GAP_RST   = 16'd400;
  localparam logic [MS_W-1:0]    HOLD_RST      = 16'd2000;
  localparam logic [COUNT_W-1:0] COUNT_MAX     = 8'd255;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_GAP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_COUNTING = 2'd1,
    PH_HOLDING  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_ONE      = 3'd1,
    ACT_TWO      = 3'd2,
    ACT_THREE    = 3'd3,
    ACT_HOLD     = 3'd4,
    ACT_UNMAPPED = 3'd5
  } action_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] analog_threshold;
    logic [MS_W-1:0]    tap_gap_ms;
    logic [MS_W-1:0]    hold_ms;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] time_ms;
    logic              touch;
  } sample_t;

  typedef struct packed {
    action_t            action;
    logic [COUNT_W-1:0] taps_counted;
    phase_t             gesture_phase;
  } result_t;

endpackage

// ===== hdl/tthg_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tthg_cfg_regs
// Configuration registers: threshold, tap gap and hold time.
// ----------------------------------------------------------------------------
module tthg_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tthg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tthg_pkg::CFG_DATA_W-1:0]  cfg_data,
  output tthg_pkg::cfg_t                   cfg
);

  tthg_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        tthg_pkg::CFG_THRESHOLD:
          cfg_nxt.analog_threshold = cfg_data[tthg_pkg::LEVEL_W-1:0];
        tthg_pkg::CFG_TAP_GAP: cfg_nxt.tap_gap_ms = cfg_data;
        tthg_pkg::CFG_HOLD:    cfg_nxt.hold_ms    = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.analog_threshold <= tthg_pkg::THRESHOLD_RST;
      cfg_r.tap_gap_ms       <= tthg_pkg::TAP_GAP_RST;
      cfg_r.hold_ms          <= tthg_pkg::HOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/tthg_in_stage.sv =====
// ----------------------------------------------------------------------------
// tthg_in_stage
// Input register: takes one sample word and resolves the touch level.
// ----------------------------------------------------------------------------
module tthg_in_stage (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  logic                                drain,
  input  logic [tthg_pkg::TIME_W-1:0]         time_ms,
  input  logic                                digital_pad,
  input  logic [tthg_pkg::LEVEL_W-1:0]        analog_level,
  input  logic [tthg_pkg::LEVEL_W-1:0]        analog_threshold,
  output logic                                valid,
  output tthg_pkg::sample_t                   sample
);

  logic              valid_r, valid_nxt;
  tthg_pkg::sample_t sample_r, sample_nxt;

  always_comb begin
    valid_nxt  = valid_r;
    sample_nxt = sample_r;
    if (accept) begin
      valid_nxt          = 1'b1;
      sample_nxt.time_ms = time_ms;
      sample_nxt.touch   = digital_pad | (analog_level > analog_threshold);
    end else if (drain) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
  end

  assign valid  = valid_r;
  assign sample = sample_r;

endmodule

// ===== hdl/tthg_gesture.sv =====
// ----------------------------------------------------------------------------
// tthg_gesture
// Gesture state: edge detection, tap counting, hold and timeout decisions.
// ----------------------------------------------------------------------------
module tthg_gesture (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  tthg_pkg::sample_t    sample,
  input  tthg_pkg::cfg_t       cfg,
  output tthg_pkg::result_t    result
);

  tthg_pkg::phase_t                 phase_r, phase_nxt;
  logic                             prev_touch_r, prev_touch_nxt;
  logic [tthg_pkg::COUNT_W-1:0]     count_r, count_nxt;
  logic [tthg_pkg::TIME_W-1:0]      press_r, press_nxt;
  logic [tthg_pkg::TIME_W-1:0]      last_r, last_nxt;

  logic                             rise, fall;
  logic [tthg_pkg::TIME_W-1:0]      dt_last, dt_press;
  logic                             in_gap, past_gap, past_hold;
  logic                             hold_hit, timeout_hit;
  tthg_pkg::action_t                action;

  assign rise     = ~prev_touch_r & sample.touch;
  assign fall     = prev_touch_r & ~sample.touch;
  assign dt_last  = sample.time_ms - last_r;
  assign dt_press = sample.time_ms - press_r;
  assign in_gap   = dt_last < {{(tthg_pkg::TIME_W-tthg_pkg::MS_W){1'b0}}, cfg.tap_gap_ms};
  assign past_gap = dt_last > {{(tthg_pkg::TIME_W-tthg_pkg::MS_W){1'b0}}, cfg.tap_gap_ms};
  assign past_hold = dt_press > {{(tthg_pkg::TIME_W-tthg_pkg::MS_W){1'b0}}, cfg.hold_ms};

  // A press on its own sample has zero elapsed time, so it can never hold
  // right away; the hold check only looks at a press already under way.
  assign hold_hit = sample.touch & ~rise & (phase_r == tthg_pkg::PH_COUNTING) &
                    (count_r == {{(tthg_pkg::COUNT_W-1){1'b0}}, 1'b1}) & past_hold;

  // While released there is no new press, so the stored tap time is current.
  assign timeout_hit = ~sample.touch & (phase_r == tthg_pkg::PH_COUNTING) & past_gap;

  // Next state.
  always_comb begin
    phase_nxt      = phase_r;
    count_nxt      = count_r;
    press_nxt      = press_r;
    last_nxt       = last_r;
    prev_touch_nxt = sample.touch;
    if (rise) begin
      press_nxt = sample.time_ms;
      last_nxt  = sample.time_ms;
      if ((phase_r == tthg_pkg::PH_COUNTING) && in_gap) begin
        if (count_r != tthg_pkg::COUNT_MAX) begin
          count_nxt = count_r + 1'b1;
        end
      end else begin
        count_nxt = {{(tthg_pkg::COUNT_W-1){1'b0}}, 1'b1};
        phase_nxt = tthg_pkg::PH_COUNTING;
      end
    end
    if (hold_hit) begin
      phase_nxt = tthg_pkg::PH_HOLDING;
      count_nxt = '0;
    end
    if (fall && (phase_r == tthg_pkg::PH_HOLDING)) begin
      phase_nxt = tthg_pkg::PH_IDLE;
    end
    if (timeout_hit) begin
      phase_nxt = tthg_pkg::PH_IDLE;
      count_nxt = '0;
    end
  end

  // Outputs.
  always_comb begin
    action = tthg_pkg::ACT_NONE;
    if (timeout_hit) begin
      unique case (count_r)
        8'd1:    action = tthg_pkg::ACT_ONE;
        8'd2:    action = tthg_pkg::ACT_TWO;
        8'd3:    action = tthg_pkg::ACT_THREE;
        default: action = tthg_pkg::ACT_UNMAPPED;
      endcase
    end else if (hold_hit) begin
      action = tthg_pkg::ACT_HOLD;
    end
    result.action        = action;
    result.taps_counted  = count_nxt;
    result.gesture_phase = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= tthg_pkg::PH_IDLE;
      prev_touch_r <= 1'b0;
      count_r      <= '0;
      press_r      <= '0;
      last_r       <= '0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      prev_touch_r <= prev_touch_nxt;
      count_r      <= count_nxt;
      press_r      <= press_nxt;
      last_r       <= last_nxt;
    end
  end

endmodule

// ===== hdl/tthg_out_stage.sv =====
// ----------------------------------------------------------------------------
// tthg_out_stage
// Result register: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module tthg_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  tthg_pkg::result_t   result,
  input  logic                out_tready,
  output logic                out_tvalid,
  output logic                free,
  output tthg_pkg::result_t   held
);

  logic              valid_r, valid_nxt;
  tthg_pkg::result_t held_r, held_nxt;

  always_comb begin
    valid_nxt = valid_r;
    held_nxt  = held_r;
    if (load) begin
      valid_nxt = 1'b1;
      held_nxt  = result;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

  assign out_tvalid = valid_r;
  assign free       = ~valid_r | out_tready;
  assign held       = held_r;

endmodule

// ===== hdl/touch_tap_hold_gesture_detector_core.sv =====
// A sample word is registered in the input stage, then its result word in the result
// register when free. Throughput: one sample per cycle while results are taken;
// the gesture state logic is combinational: a 32-bit time subtract and compare.
// Reset: synchronous, active low; clears the gesture state and both stages and
// loads the configuration defaults (threshold 500, tap gap 400 ms, hold 2000 ms).
// ----------------------------------------------------------------------------
// touch_tap_hold_gesture_detector_core
// Multi-tap and long-press detector for a digital plus analog touch input.
// ----------------------------------------------------------------------------
module touch_tap_hold_gesture_detector_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // time_ms [31:0], digital_pad [32], analog_level [42:33], zero fill [47:43]
  input  logic [tthg_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // action [2:0], taps_counted [10:3], gesture_phase [12:11], zero fill [15:13]
  output logic [tthg_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_we,
  input  logic [tthg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tthg_pkg::CFG_DATA_W-1:0]      cfg_data
);

  tthg_pkg::cfg_t    cfg;
  tthg_pkg::sample_t sample;
  tthg_pkg::result_t result, held;
  logic              s1_valid, out_free, fire, in_accept;

  // The input stage drains into the result register whenever that is free.
  assign fire      = s1_valid & out_free;
  assign in_tready = ~s1_valid | out_free;
  assign in_accept = in_tvalid & in_tready;

  tthg_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tthg_in_stage u_in (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (in_accept),
    .drain            (fire),
    .time_ms          (in_tdata[31:0]),
    .digital_pad      (in_tdata[32]),
    .analog_level     (in_tdata[42:33]),
    .analog_threshold (cfg.analog_threshold),
    .valid            (s1_valid),
    .sample           (sample)
  );

  tthg_gesture u_gesture (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .sample (sample),
    .cfg    (cfg),
    .result (result)
  );

  tthg_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .result     (result),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .free       (out_free),
    .held       (held)
  );

  assign out_tdata = {3'b000, held.gesture_phase, held.taps_counted, held.action};

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tap/hold gesture detector core.
// A queue of touch sample words feeds a stream driver. Each accepted word runs
// through an in-bench model of the gesture state, and the predicted result
// waits in a queue. A monitor compares every result word field by field.
// The run goes through directed gestures, a tap count that saturates under a
// long receiver stall, and random gestures under several register settings
// and idle patterns.
// ----------------------------------------------------------------------------
module tb;

  localparam int          CYCLE_LIMIT     = 400000;
  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int          PHASE_WORDS     = 180;
  localparam int          FILL_W          = tthg_pkg::IN_TDATA_W - tthg_pkg::TIME_W - 1 -
                                            tthg_pkg::LEVEL_W;
  localparam logic [tthg_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [tthg_pkg::LEVEL_W-1:0] level;
    logic                         pad;
    logic [tthg_pkg::TIME_W-1:0]  time_ms;
  } touch_word_t;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic [tthg_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [tthg_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic                             cfg_we     = 1'b0;
  logic [tthg_pkg::CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [tthg_pkg::CFG_DATA_W-1:0]  cfg_data   = '0;

  // Register mirror, loaded with the reset defaults.
  logic [tthg_pkg::LEVEL_W-1:0] thr_cfg  = tthg_pkg::THRESHOLD_RST;
  logic [tthg_pkg::MS_W-1:0]    gap_cfg  = tthg_pkg::TAP_GAP_RST;
  logic [tthg_pkg::MS_W-1:0]    hold_cfg = tthg_pkg::HOLD_RST;

  // Gesture state of the in-bench model.
  tthg_pkg::phase_t             ph         = tthg_pkg::PH_IDLE;
  logic                         prev_touch = 1'b0;
  logic [tthg_pkg::COUNT_W-1:0] taps       = '0;
  logic [tthg_pkg::TIME_W-1:0]  press_t    = '0;
  logic [tthg_pkg::TIME_W-1:0]  last_t     = '0;

  touch_word_t       touch_samples[$];
  tthg_pkg::result_t gesture_reports[$];
  touch_word_t       next_word;
  tthg_pkg::result_t want;

  int unsigned issued_cnt    = 0;
  int unsigned presented_cnt = 0;
  int unsigned accepted_cnt  = 0;
  int unsigned errors        = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_off_req  = 0;
  int unsigned hold_off_seen = 0;
  int unsigned hold_off_left = 0;
  logic [tthg_pkg::TIME_W-1:0] clock_ms = '0;

  touch_tap_hold_gesture_detector_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic tthg_pkg::result_t gesture_update(
      input logic [tthg_pkg::TIME_W-1:0]  now,
      input logic                         pad,
      input logic [tthg_pkg::LEVEL_W-1:0] level);
    logic                        touched;
    logic [tthg_pkg::TIME_W-1:0] since_tap;
    logic [tthg_pkg::TIME_W-1:0] since_press;
    tthg_pkg::result_t           r;
    touched  = pad | (level > thr_cfg);
    r.action = tthg_pkg::ACT_NONE;
    if (!prev_touch && touched) begin
      press_t   = now;
      since_tap = now - last_t;
      if (ph == tthg_pkg::PH_COUNTING && since_tap < tthg_pkg::TIME_W'(gap_cfg)) begin
        if (taps != tthg_pkg::COUNT_MAX) taps = taps + 1'b1;
      end else begin
        taps = 8'd1;
        ph   = tthg_pkg::PH_COUNTING;
      end
      last_t = now;
    end
    since_press = now - press_t;
    if (touched && ph == tthg_pkg::PH_COUNTING && taps == 8'd1 &&
        since_press > tthg_pkg::TIME_W'(hold_cfg)) begin
      ph       = tthg_pkg::PH_HOLDING;
      taps     = '0;
      r.action = tthg_pkg::ACT_HOLD;
    end
    if (prev_touch && !touched && ph == tthg_pkg::PH_HOLDING) ph = tthg_pkg::PH_IDLE;
    since_tap = now - last_t;
    if (ph == tthg_pkg::PH_COUNTING && !touched &&
        since_tap > tthg_pkg::TIME_W'(gap_cfg)) begin
      case (taps)
        8'd1:    r.action = tthg_pkg::ACT_ONE;
        8'd2:    r.action = tthg_pkg::ACT_TWO;
        8'd3:    r.action = tthg_pkg::ACT_THREE;
        default: r.action = tthg_pkg::ACT_UNMAPPED;
      endcase
      taps = '0;
      ph   = tthg_pkg::PH_IDLE;
    end
    prev_touch      = touched;
    r.taps_counted  = taps;
    r.gesture_phase = ph;
    return r;
  endfunction

  // Sender: a new word goes out only once the previous one has been taken.
  always @(negedge clk) begin
    if (rst_n && presented_cnt == accepted_cnt) begin
      if (touch_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_word = touch_samples.pop_front();
        in_tdata  <= {{FILL_W{1'b0}}, next_word};
        in_tvalid <= 1'b1;
        presented_cnt++;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      gesture_reports.push_back(gesture_update(
          in_tdata[tthg_pkg::TIME_W-1:0], in_tdata[tthg_pkg::TIME_W],
          in_tdata[tthg_pkg::TIME_W+tthg_pkg::LEVEL_W:tthg_pkg::TIME_W+1]));
      accepted_cnt++;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (hold_off_left != 0) begin
      hold_off_left--;
      out_tready <= 1'b0;
    end else if (hold_off_seen != hold_off_req) begin
      hold_off_seen = hold_off_req;
      hold_off_left = HOLD_OFF_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (gesture_reports.size() == 0) begin
        $display("%0t: result word %h with no sample waiting", $time, out_tdata);
        errors++;
      end else begin
        want = gesture_reports.pop_front();
        if (out_tdata[2:0] !== want.action) begin
          $display("%0t: action expected %0d actual %0d", $time, want.action, out_tdata[2:0]);
          errors++;
        end
        if (out_tdata[10:3] !== want.taps_counted) begin
          $display("%0t: taps_counted expected %0d actual %0d", $time, want.taps_counted,
                   out_tdata[10:3]);
          errors++;
        end
        if (out_tdata[12:11] !== want.gesture_phase) begin
          $display("%0t: gesture_phase expected %0d actual %0d", $time, want.gesture_phase,
                   out_tdata[12:11]);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(input logic [tthg_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [tthg_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      tthg_pkg::CFG_THRESHOLD: thr_cfg  = value[tthg_pkg::LEVEL_W-1:0];
      tthg_pkg::CFG_TAP_GAP:   gap_cfg  = value;
      tthg_pkg::CFG_HOLD:      hold_cfg = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(input int unsigned thr, input int unsigned gap,
                                input int unsigned hold);
    // Upper bits of the threshold write are junk that the register drops.
    write_reg(tthg_pkg::CFG_THRESHOLD, {6'($urandom_range(63)), 10'(thr)});
    write_reg(tthg_pkg::CFG_TAP_GAP, 16'(gap));
    write_reg(tthg_pkg::CFG_HOLD, 16'(hold));
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (accepted_cnt != issued_cnt || gesture_reports.size() != 0);
  endtask

  task automatic push_raw(input logic [tthg_pkg::TIME_W-1:0] t, input logic pad,
                          input logic [tthg_pkg::LEVEL_W-1:0] level);
    touch_word_t w;
    w.time_ms = t;
    w.pad     = pad;
    w.level   = level;
    touch_samples.push_back(w);
    issued_cnt++;
  endtask

  // Touch comes either from the digital pad or from an analog level above
  // the threshold; release keeps the analog level at or below it.
  task automatic push_touch(input logic [tthg_pkg::TIME_W-1:0] t, input bit touched);
    if (!touched)
      push_raw(t, 1'b0, tthg_pkg::LEVEL_W'($urandom_range(int'(thr_cfg), 0)));
    else if (thr_cfg == {tthg_pkg::LEVEL_W{1'b1}} || $urandom_range(1) == 0)
      push_raw(t, 1'b1, tthg_pkg::LEVEL_W'($urandom_range(1023)));
    else
      push_raw(t, 1'b0, tthg_pkg::LEVEL_W'($urandom_range(1023, int'(thr_cfg) + 1)));
  endtask

  task automatic sample_at(input int unsigned dt, input bit touched);
    clock_ms = clock_ms + dt;
    push_touch(clock_ms, touched);
  endtask

  task automatic play_taps(input int n);
    int unsigned g;
    int unsigned sp;
    int unsigned r;
    g = 32'(gap_cfg);
    sample_at($urandom_range(300, 1), 1'b1);
    for (int k = 0; k < n; k++) begin
      if (k == n - 1) sp = g + $urandom_range(2);
      else begin
        case ($urandom_range(7))
          0:       sp = g;
          1:       sp = (g > 1) ? g - 1 : 1;
          default: sp = (g > 2) ? $urandom_range(g - 1, 2) : 2;
        endcase
      end
      if (sp < 2) sp = 2;
      r = $urandom_range(sp - 1, 1);
      if (r >= 2 && $urandom_range(3) == 0) begin
        sample_at(r / 2, 1'b1);
        sample_at(r - r / 2, 1'b0);
      end else begin
        sample_at(r, 1'b0);
      end
      sample_at(sp - r, k != n - 1);
    end
    if ($urandom_range(1) == 0) sample_at($urandom_range(g + 5, 1), 1'b0);
  endtask

  task automatic play_hold();
    int unsigned h;
    h = 32'(hold_cfg);
    sample_at($urandom_range(300, 1), 1'b1);
    sample_at(h / 2, 1'b1);
    sample_at(h - h / 2 + $urandom_range(2), 1'b1);
    repeat ($urandom_range(2)) sample_at($urandom_range(100), 1'b1);
    sample_at($urandom_range(100, 1), 1'b0);
    sample_at(int'(gap_cfg) + $urandom_range(5, 1), 1'b0);
  endtask

  // Broken sequences: arbitrary pads, jumps, backward time and the wrap.
  task automatic play_noise();
    repeat ($urandom_range(4, 1)) begin
      case ($urandom_range(3))
        0:       clock_ms = $urandom;
        1:       clock_ms = clock_ms - $urandom_range(1000);
        2:       clock_ms = 32'hFFFF_FFFF - $urandom_range(300);
        default: clock_ms = clock_ms + $urandom_range(3);
      endcase
      push_raw(clock_ms, 1'($urandom_range(1)), tthg_pkg::LEVEL_W'($urandom_range(1023)));
    end
  endtask

  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct);
    int unsigned start;
    int unsigned pick;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    start = issued_cnt;
    while (issued_cnt - start < PHASE_WORDS) begin
      pick = $urandom_range(9);
      if (pick < 6)
        play_taps(($urandom_range(9) == 0) ? $urandom_range(6, 4) : $urandom_range(3, 1));
      else if (pick < 8) play_hold();
      else play_noise();
    end
    wait_drained();
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // A write to the spare index must leave the defaults in place.
    write_reg(CFG_SPARE, 16'($urandom));

    // Analog level equal to the threshold is released; one above is touched.
    // The timeout needs strictly more than the gap.
    push_raw(32'd10, 1'b0, 10'd500);
    push_raw(32'd20, 1'b0, 10'd501);
    push_raw(32'd30, 1'b0, 10'd0);
    push_raw(32'd420, 1'b0, 10'd0);
    push_raw(32'd421, 1'b0, 10'd0);
    // Two taps just inside the gap.
    push_raw(32'd1000, 1'b1, 10'd0);
    push_raw(32'd1001, 1'b0, 10'd0);
    push_raw(32'd1399, 1'b1, 10'd0);
    push_raw(32'd1400, 1'b0, 10'd0);
    push_raw(32'd1800, 1'b0, 10'd0);
    // Three taps across the timestamp wrap; the release also times out.
    push_raw(32'hFFFF_FFF0, 1'b1, 10'd1023);
    push_raw(32'hFFFF_FFF8, 1'b0, 10'd0);
    push_raw(32'h0000_0005, 1'b1, 10'd0);
    push_raw(32'h0000_0006, 1'b0, 10'd0);
    push_raw(32'h0000_0010, 1'b1, 10'd0);
    push_raw(32'h0000_01A1, 1'b0, 10'd0);
    // Hold: exactly the hold time is not enough. Release goes back in time.
    push_raw(32'd5000, 1'b0, 10'd1023);
    push_raw(32'd7000, 1'b0, 10'd1023);
    push_raw(32'd7001, 1'b1, 10'd1023);
    push_raw(32'd6000, 1'b0, 10'd0);
    // Four taps map to the unmapped action.
    push_raw(32'd8000, 1'b1, 10'd0);
    push_raw(32'd8001, 1'b0, 10'd0);
    push_raw(32'd8010, 1'b1, 10'd0);
    push_raw(32'd8011, 1'b0, 10'd0);
    push_raw(32'd8020, 1'b1, 10'd0);
    push_raw(32'd8021, 1'b0, 10'd0);
    push_raw(32'd8030, 1'b1, 10'd0);
    push_raw(32'd8431, 1'b0, 10'd0);
    wait_drained();

    // The tap count runs into saturation while the receiver holds off and the
    // sender keeps the input full.
    apply_settings(500, 400, 2000);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_req++;
    clock_ms = 32'd20000;
    repeat (260) begin
      sample_at(1, 1'b1);
      sample_at(1, 1'b0);
    end
    sample_at(401, 1'b0);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: apply_settings(0, 0, 0);
        1: apply_settings(1023, 65535, 65535);
        2: apply_settings($urandom_range(1023), $urandom_range(800, 2), $urandom_range(2500, 1));
        3: apply_settings(500, 400, 2000);
        7: apply_settings($urandom_range(1023), $urandom_range(65535), $urandom_range(65535));
        default:
          apply_settings($urandom_range(1023), $urandom_range(1500), $urandom_range(4000));
      endcase
      case (p % 4)
        0:       run_phase(0, 0);
        1:       run_phase(71, 0);
        2:       run_phase(0, 71);
        default: run_phase(27, 27);
      endcase
    end

    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/tthg_pkg.sv
hdl/tthg_cfg_regs.sv
hdl/tthg_in_stage.sv
hdl/tthg_gesture.sv
hdl/tthg_out_stage.sv
hdl/touch_tap_hold_gesture_detector_core.sv
tb/sv/tb.sv
